### hw/rtl/ffcu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffcu_pkg
// Types, constants and cell rules shared by the forest fire cell update core.
// ----------------------------------------------------------------------------
package ffcu_pkg;

  localparam int MAX_WIDTH   = 512;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_LEN_W   = 10;
  localparam int THR_W       = 16;
  localparam int DRAW_W      = 15;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QCOUNT_W    = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_GROW       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LIGHTNING  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_LENGTH = 2'd2;

  localparam logic [THR_W-1:0]     GROW_RESET       = 16'd655;
  localparam logic [THR_W-1:0]     LIGHTNING_RESET  = 16'd33;
  localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RESET = 10'd512;
  localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_MIN   = 10'd2;
  localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_MAX   = ROW_LEN_W'(MAX_WIDTH);

  typedef logic [1:0] cell_t;
  localparam cell_t CELL_EMPTY = 2'd0;
  localparam cell_t CELL_TREE  = 2'd1;
  localparam cell_t CELL_FIRE  = 2'd2;

  typedef logic [1:0] phase_t;
  localparam phase_t PHASE_FIRST  = 2'd0;
  localparam phase_t PHASE_SECOND = 2'd1;
  localparam phase_t PHASE_LATER  = 2'd2;

  typedef cell_t [8:0] window_t;

  typedef struct packed {
    cell_t               cell_state;
    logic                frame_start;
    logic [DRAW_W-1:0]   draw_first;
    logic [DRAW_W-1:0]   draw_second;
  } in_item_t;

  typedef struct packed {
    cell_t next_state;
    logic  end_of_row;
    logic  last;
  } out_item_t;

  typedef struct packed {
    cell_t upper;
    cell_t middle;
  } line_t;

  localparam int LINE_W = $bits(line_t);

  typedef struct packed {
    cell_t top;
    cell_t mid;
    cell_t bot;
  } column_t;

  typedef struct packed {
    logic [THR_W-1:0] grow;
    logic [THR_W-1:0] lightning;
  } thresholds_t;

  typedef struct packed {
    logic                valid;
    logic [QCOUNT_W-1:0] count;
    out_item_t           first;
    out_item_t           second;
  } push_t;

  typedef struct packed {
    logic [QCOUNT_W-1:0] room;
  } queue_status_t;

  function automatic window_t shift_window(window_t w, column_t col);
    window_t n;
    n = w;
    for (int r = 0; r < 3; r++) begin
      n[r*3]   = w[r*3+1];
      n[r*3+1] = w[r*3+2];
    end
    n[2] = col.top;
    n[5] = col.mid;
    n[8] = col.bot;
    return n;
  endfunction

  function automatic cell_t next_cell(window_t w, logic [DRAW_W-1:0] draw, thresholds_t thr);
    logic burning;
    cell_t res;
    burning = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4 && w[i] == CELL_FIRE) burning = 1'b1;
    end
    if (w[4] == CELL_FIRE) begin
      res = CELL_EMPTY;
    end else if (w[4] == CELL_EMPTY) begin
      res = ({1'b0, draw} < thr.grow) ? CELL_TREE : CELL_EMPTY;
    end else begin
      res = (burning || ({1'b0, draw} < thr.lightning)) ? CELL_FIRE : CELL_TREE;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ffcu_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffcu_in_if / ffcu_out_if
// Valid/ready channels for the cell stream and the result stream.
// ----------------------------------------------------------------------------
interface ffcu_in_if import ffcu_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface ffcu_out_if import ffcu_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

### hw/rtl/ffcu_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffcu_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffcu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/ffcu_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffcu_window
// 3x3 neighbourhood window and next-state rule for the centre cell.
// ----------------------------------------------------------------------------
module ffcu_window import ffcu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              clear,
  input  column_t           col,
  input  logic [DRAW_W-1:0] draw_first,
  input  logic [DRAW_W-1:0] draw_second,
  input  thresholds_t       thr,
  output cell_t             next_first,
  output cell_t             next_second
);

  window_t win;
  window_t win_base;
  window_t win_next;
  window_t win_flush;

  localparam column_t COL_EMPTY = '{top: CELL_EMPTY, mid: CELL_EMPTY, bot: CELL_EMPTY};

  always_comb begin
    win_base    = clear ? {9{CELL_EMPTY}} : win;
    win_next    = shift_window(win_base, col);
    win_flush   = shift_window(win_next, COL_EMPTY);
    next_first  = next_cell(win_next, draw_first, thr);
    next_second = next_cell(win_flush, draw_second, thr);
  end

  // row-end flush is not kept: the next transfer always opens a row
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= {9{CELL_EMPTY}};
    end else if (load) begin
      win <= win_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ffcu_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffcu_out_queue
// Two-entry result queue; takes one or two results per transfer.
// ----------------------------------------------------------------------------
module ffcu_out_queue import ffcu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  push_t             push,
  output queue_status_t     status,
  ffcu_out_if.source        results
);

  out_item_t           q0;
  out_item_t           q1;
  out_item_t           q0_next;
  out_item_t           q1_next;
  logic [QCOUNT_W-1:0] count;
  logic [QCOUNT_W-1:0] count_next;
  logic [QCOUNT_W-1:0] count_left;
  logic                pop;

  assign results.valid   = (count != '0);
  assign results.payload = q0;
  assign pop             = results.valid && results.ready;
  assign count_left      = count - QCOUNT_W'(pop);
  assign status.room     = QCOUNT_W'(QUEUE_DEPTH) - count_left;

  always_comb begin
    q0_next    = q0;
    q1_next    = q1;
    count_next = count_left;
    if (pop) q0_next = q1;
    if (push.valid && push.count != '0) begin
      if (count_left == '0) begin
        q0_next = push.first;
        q1_next = push.second;
      end else begin
        q1_next = push.first;
      end
      count_next = count_left + push.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

endmodule
`default_nettype wire

### hw/rtl/forest_fire_cell_update_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A transferred cell is registered in s1 and its results go to the result queue;
// a row-end cell's second result follows its first. The first result is the cell
// one row and one column behind the transferred one, the second one row behind.
// Throughput: one cell per cycle; a row-end cell makes two results and the
// column-0 cell after it makes none, so the input waits only on result stalls.
// Reset (rst, synchronous): registers, counters, window and queue cleared;
// line buffer RAM is not cleared.
// ----------------------------------------------------------------------------
// forest_fire_cell_update_core
// Forest fire automaton over a raster cell stream with two line buffers.
// ----------------------------------------------------------------------------
module forest_fire_cell_update_core import ffcu_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ffcu_in_if.sink                cells,
  ffcu_out_if.source             results
);

  typedef struct packed {
    logic [COL_W-1:0]  col;
    cell_t             in_cell;
    phase_t            phase;
    logic              at_end;
    logic              fwd;
    logic [DRAW_W-1:0] draw_first;
    logic [DRAW_W-1:0] draw_second;
  } stage_t;

  thresholds_t          thr;
  logic [ROW_LEN_W-1:0] row_length;
  logic [ROW_LEN_W-1:0] row_w;
  logic [ROW_LEN_W-1:0] last_col;

  logic [COL_W-1:0]     column_count;
  phase_t               row_phase;
  logic [COL_W-1:0]     col_base;
  phase_t               phase_base;
  logic [COL_W-1:0]     col;
  logic                 at_end;
  cell_t                in_cell;
  logic                 accept;

  stage_t               s1;
  logic                 s1_valid;
  logic                 s1_commit;
  line_t                rdata;
  line_t                fwd_line;
  line_t                line_eff;
  line_t                wdata;
  column_t              win_col;
  cell_t                next_first;
  cell_t                next_second;
  logic                 has_first;
  logic                 has_second;
  push_t                push;
  queue_status_t        qstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.grow      <= GROW_RESET;
      thr.lightning <= LIGHTNING_RESET;
      row_length    <= ROW_LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GROW:       thr.grow      <= cfg_data;
        REG_LIGHTNING:  thr.lightning <= cfg_data;
        REG_ROW_LENGTH: row_length    <= cfg_data[ROW_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_length < ROW_LENGTH_MIN) row_w = ROW_LENGTH_MIN;
    else if (row_length > ROW_LENGTH_MAX) row_w = ROW_LENGTH_MAX;
    else row_w = row_length;
  end
  assign last_col = row_w - ROW_LEN_W'(1);

  // input stage: column and row position of the offered cell
  always_comb begin
    col_base   = cells.payload.frame_start ? '0 : column_count;
    phase_base = cells.payload.frame_start ? PHASE_FIRST
               : ((row_phase > PHASE_LATER) ? PHASE_LATER : row_phase);
    col        = (ROW_LEN_W'(col_base) > last_col) ? last_col[COL_W-1:0] : col_base;
    at_end     = (ROW_LEN_W'(col) == last_col);
    in_cell    = (cells.payload.cell_state > CELL_FIRE) ? CELL_EMPTY
               : cells.payload.cell_state;
  end

  assign cells.ready = !s1_valid || s1_commit;
  assign accept      = cells.valid && cells.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_phase    <= PHASE_FIRST;
      s1_valid     <= 1'b0;
    end else begin
      if (accept) begin
        column_count <= at_end ? '0 : col + COL_W'(1);
        row_phase    <= (at_end && phase_base != PHASE_LATER) ? phase_base + phase_t'(1)
                      : phase_base;
      end
      if (accept) s1_valid <= 1'b1;
      else if (s1_commit) s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.col         <= col;
      s1.in_cell     <= in_cell;
      s1.phase       <= phase_base;
      s1.at_end      <= at_end;
      s1.fwd         <= s1_commit && (s1.col == col);
      s1.draw_first  <= cells.payload.draw_first;
      s1.draw_second <= cells.payload.draw_second;
    end
    if (s1_commit) fwd_line <= wdata;
  end

  ffcu_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk  (clk),
    .we   (s1_commit),
    .waddr(s1.col),
    .wdata(wdata),
    .re   (accept),
    .raddr(col),
    .rdata(rdata)
  );

  // same column written in the cycle it was read: take the write data
  always_comb begin
    line_eff     = s1.fwd ? fwd_line : rdata;
    wdata.upper  = line_eff.middle;
    wdata.middle = s1.in_cell;
    win_col.top  = (s1.phase == PHASE_SECOND) ? CELL_EMPTY : line_eff.upper;
    win_col.mid  = line_eff.middle;
    win_col.bot  = s1.in_cell;
  end

  ffcu_window u_window (
    .clk        (clk),
    .rst        (rst),
    .load       (s1_commit),
    .clear      (s1.col == '0),
    .col        (win_col),
    .draw_first (s1.draw_first),
    .draw_second(s1.draw_second),
    .thr        (thr),
    .next_first (next_first),
    .next_second(next_second)
  );

  always_comb begin
    has_first   = (s1.phase != PHASE_FIRST) && (s1.col != '0);
    has_second  = (s1.phase != PHASE_FIRST) && s1.at_end;
    push.count  = QCOUNT_W'(has_first) + QCOUNT_W'(has_second);
    push.second = '{next_state: next_second, end_of_row: 1'b1, last: 1'b1};
    push.first  = has_first ? '{next_state: next_first, end_of_row: 1'b0, last: !s1.at_end}
                : push.second;
    s1_commit   = s1_valid && (push.count <= qstat.room);
    push.valid  = s1_commit;
  end

  ffcu_out_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .status (qstat),
    .results(results)
  );

endmodule
`default_nettype wire

### hw/rtl/ffcu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffcu_checker
// Port-level checks on the result stream of the cell update core.
// ----------------------------------------------------------------------------
module ffcu_checker import ffcu_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      res_valid,
  input logic      res_ready,
  input out_item_t res_item
);

  // offered result is held until transfer
  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result valid dropped before transfer");

  a_payload_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_item))
    else $error("result payload changed while stalled");

  // first of a row-end pair is followed at once by the row-end cell
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res_item.last |=> res_valid && res_item.end_of_row)
    else $error("row-end result missing after first of pair");

  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result offered straight after reset");

endmodule

bind forest_fire_cell_update_core ffcu_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .res_valid(results.valid),
  .res_ready(results.ready),
  .res_item (results.payload)
);
`default_nettype wire

### test/tb_forest_fire_cell_update_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_forest_fire_cell_update_core
// Streams forest grids into the cell update core and checks every emitted
// cell. The first part is a short table of hand-worked cells. After it come a
// mid-row shrink of the row length, a full-width row and the next row's start
// held up by a long result stall, and randomised frames over many register
// settings and handshake patterns. Each result is compared with its pinned
// value or a cycle-free model of window and line buffers kept in this bench.
// ----------------------------------------------------------------------------
module tb_forest_fire_cell_update_core;
  import ffcu_pkg::*;

  localparam cell_t CELL_UNUSED    = 2'd3;
  localparam int    NOT_PINNED     = -1;
  localparam int    HOLD_CYCLES    = 300;
  localparam int    QUIET_LIMIT    = 2000;
  localparam int    RANDOM_ITEMS   = 950;
  localparam int    PRESSURE_CELLS = 32;

  typedef struct {
    in_item_t item;
    int       pinned_count;
    cell_t    pin_first;
    cell_t    pin_second;
  } stim_t;

  typedef struct {
    cell_t cell_in;
    bit    fs;
    int    draw1;
    int    draw2;
    int    results;
    cell_t first;
    cell_t second;
  } directed_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  ffcu_in_if  cells_ch ();
  ffcu_out_if results_ch ();

  forest_fire_cell_update_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cells     (cells_ch),
    .results   (results_ch)
  );

  always #5ns clk = ~clk;

  // model state
  logic [THR_W-1:0]     grow_thr  = GROW_RESET;
  logic [THR_W-1:0]     spark_thr = LIGHTNING_RESET;
  logic [ROW_LEN_W-1:0] row_len   = ROW_LENGTH_RESET;
  cell_t                above_row  [MAX_WIDTH] = '{default: CELL_EMPTY};
  cell_t                centre_row [MAX_WIDTH] = '{default: CELL_EMPTY};
  cell_t                nbhd [9] = '{default: CELL_EMPTY};
  int                   col_pos = 0;
  phase_t               stage = PHASE_FIRST;

  out_item_t expected_cells [$];
  stim_t     cell_queue [$];
  stim_t     on_bus;
  int        mismatches = 0;
  int        gap_pct = 0;
  int        stall_pct = 0;
  int        fire_pct = 10;
  int        tree_pct = 50;
  int        random_items = 0;
  bit        hold_request = 1'b0;
  int        hold_left = 0;
  int        quiet_cycles = 0;

  directed_row_t directed_rows [22] = '{
    '{CELL_EMPTY,  1'b1, 0,     0,     0, CELL_EMPTY, CELL_EMPTY},
    '{CELL_TREE,   1'b0, 32767, 32767, 0, CELL_EMPTY, CELL_EMPTY},
    '{CELL_TREE,   1'b0, 0,     0,     0, CELL_EMPTY, CELL_EMPTY},
    '{CELL_TREE,   1'b0, 0,     0,     0, CELL_EMPTY, CELL_EMPTY},
    '{CELL_UNUSED, 1'b0, 654,   0,     1, CELL_TREE,  CELL_EMPTY},
    '{CELL_TREE,   1'b0, 33,    32,    2, CELL_TREE,  CELL_FIRE},
    '{CELL_FIRE,   1'b0, 0,     0,     0, CELL_EMPTY, CELL_EMPTY},
    '{CELL_TREE,   1'b0, 32767, 0,     1, CELL_FIRE,  CELL_EMPTY},
    '{CELL_EMPTY,  1'b0, 0,     655,   2, CELL_TREE,  CELL_TREE},
    '{CELL_EMPTY,  1'b0, 0,     0,     0, CELL_EMPTY, CELL_EMPTY},
    '{CELL_EMPTY,  1'b0, 0,     0,     1, CELL_EMPTY, CELL_EMPTY},
    '{CELL_EMPTY,  1'b0, 32767, 655,   2, CELL_FIRE,  CELL_EMPTY},
    '{CELL_EMPTY,  1'b0, 0,     0,     0, CELL_EMPTY, CELL_EMPTY},
    '{CELL_TREE,   1'b1, 0,     0,     0, CELL_EMPTY, CELL_EMPTY},
    '{CELL_FIRE,   1'b0, 0,     0,     0, CELL_EMPTY, CELL_EMPTY},
    '{CELL_UNUSED, 1'b0, 0,     0,     0, CELL_EMPTY, CELL_EMPTY},
    '{CELL_EMPTY,  1'b0, 7,     9,     NOT_PINNED, CELL_EMPTY, CELL_EMPTY},
    '{CELL_FIRE,   1'b0, 32767, 0,     NOT_PINNED, CELL_EMPTY, CELL_EMPTY},
    '{CELL_TREE,   1'b0, 12345, 21845, NOT_PINNED, CELL_EMPTY, CELL_EMPTY},
    '{CELL_TREE,   1'b0, 0,     32767, NOT_PINNED, CELL_EMPTY, CELL_EMPTY},
    '{CELL_TREE,   1'b0, 21845, 10922, NOT_PINNED, CELL_EMPTY, CELL_EMPTY},
    '{CELL_EMPTY,  1'b0, 1,     2,     NOT_PINNED, CELL_EMPTY, CELL_EMPTY}
  };

  function automatic int clamp_width(int n);
    if (n < int'(ROW_LENGTH_MIN)) return int'(ROW_LENGTH_MIN);
    if (n > int'(ROW_LENGTH_MAX)) return int'(ROW_LENGTH_MAX);
    return n;
  endfunction

  function automatic void slide_window(cell_t top, cell_t mid, cell_t bot);
    for (int r = 0; r < 3; r++) begin
      nbhd[r*3]   = nbhd[r*3+1];
      nbhd[r*3+1] = nbhd[r*3+2];
    end
    nbhd[2] = top;
    nbhd[5] = mid;
    nbhd[8] = bot;
  endfunction

  function automatic cell_t evolve(logic [DRAW_W-1:0] draw);
    bit burning;
    burning = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4 && nbhd[i] == CELL_FIRE) burning = 1'b1;
    end
    case (nbhd[4])
      CELL_FIRE:  return CELL_EMPTY;
      CELL_EMPTY: return ({1'b0, draw} < grow_thr) ? CELL_TREE : CELL_EMPTY;
      default:    return (burning || {1'b0, draw} < spark_thr) ? CELL_FIRE : CELL_TREE;
    endcase
  endfunction

  task automatic predict_cells(input stim_t s);
    cell_t     incoming, top, mid;
    int        span, c;
    bit        at_end;
    out_item_t r;
    out_item_t forecast [$];
    incoming = (s.item.cell_state == CELL_UNUSED) ? CELL_EMPTY : s.item.cell_state;
    span = clamp_width(int'(row_len));
    if (s.item.frame_start) begin
      col_pos = 0;
      stage = PHASE_FIRST;
    end
    c = (col_pos > span - 1) ? span - 1 : col_pos;
    at_end = (c == span - 1);
    if (c == 0) nbhd = '{default: CELL_EMPTY};
    top = (stage == PHASE_SECOND) ? CELL_EMPTY : above_row[c];
    mid = centre_row[c];
    slide_window(top, mid, incoming);
    above_row[c] = centre_row[c];
    centre_row[c] = incoming;
    if (stage != PHASE_FIRST && c != 0) begin
      r.next_state = evolve(s.item.draw_first);
      r.end_of_row = 1'b0;
      r.last = !at_end;
      forecast.push_back(r);
    end
    if (stage != PHASE_FIRST && at_end) begin
      slide_window(CELL_EMPTY, CELL_EMPTY, CELL_EMPTY);
      r.next_state = evolve(s.item.draw_second);
      r.end_of_row = 1'b1;
      r.last = 1'b1;
      forecast.push_back(r);
    end
    if (at_end) begin
      col_pos = 0;
      if (stage != PHASE_LATER) stage = stage + 1'b1;
    end else begin
      col_pos = c + 1;
    end
    if (s.pinned_count == NOT_PINNED) begin
      foreach (forecast[k]) expected_cells.push_back(forecast[k]);
    end else begin
      for (int k = 0; k < s.pinned_count; k++) begin
        r.next_state = (k == 0) ? s.pin_first : s.pin_second;
        r.end_of_row = (k == 1);
        r.last = (k == s.pinned_count - 1);
        expected_cells.push_back(r);
      end
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_cells.size() == 0) begin
      $error("unexpected result: next_state %0d end_of_row %0d last %0d",
             got.next_state, got.end_of_row, got.last);
      mismatches++;
    end else begin
      want = expected_cells.pop_front();
      if (got.next_state !== want.next_state) begin
        $error("next_state: expected %0d, actual %0d", want.next_state, got.next_state);
        mismatches++;
      end
      if (got.end_of_row !== want.end_of_row) begin
        $error("end_of_row: expected %0d, actual %0d", want.end_of_row, got.end_of_row);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        mismatches++;
      end
    end
  endtask

  // sender: predicts on each input transfer
  always @(posedge clk) begin
    if (rst) begin
      cells_ch.valid <= 1'b0;
    end else begin
      if (cells_ch.valid && cells_ch.ready) predict_cells(on_bus);
      if (!cells_ch.valid || cells_ch.ready) begin
        if (cell_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
          on_bus = cell_queue.pop_front();
          cells_ch.valid   <= 1'b1;
          cells_ch.payload <= on_bus.item;
        end else begin
          cells_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else begin
      if (results_ch.valid && results_ch.ready) check_result(results_ch.payload);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((cells_ch.valid && cells_ch.ready) || (results_ch.valid && results_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_GROW:       grow_thr = data;
      REG_LIGHTNING:  spark_thr = data;
      REG_ROW_LENGTH: row_len = data[ROW_LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [THR_W-1:0] grow, input logic [THR_W-1:0] spark,
                          input logic [CFG_DATA_W-1:0] row_data);
    write_reg(REG_GROW, grow);
    write_reg(REG_LIGHTNING, spark);
    write_reg(REG_ROW_LENGTH, row_data);
    cfg_write <= 1'b0;
  endtask

  // block idle: nothing queued, offered or outstanding, plus the core's latency
  task automatic settle();
    while (cell_queue.size() != 0 || cells_ch.valid || expected_cells.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic cell_t random_cell();
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return CELL_UNUSED;
    if (roll < 3 + fire_pct) return CELL_FIRE;
    if (roll < 3 + fire_pct + tree_pct) return CELL_TREE;
    return CELL_EMPTY;
  endfunction

  function automatic logic [DRAW_W-1:0] random_draw();
    if ($urandom_range(3) == 0) return DRAW_W'($urandom_range(0, 1200));
    return DRAW_W'($urandom_range(0, 32767));
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold(logic [THR_W-1:0] typical);
    case ($urandom_range(5))
      0:       return '0;
      1:       return typical;
      2:       return 16'd32767;
      3:       return 16'd32768;
      4:       return 16'hFFFF;
      default: return THR_W'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic queue_row(input int count, input bit fs_first, input bit padding,
                           input bit noisy);
    stim_t s;
    for (int i = 0; i < count; i++) begin
      s.item.cell_state  = padding ? CELL_EMPTY : random_cell();
      s.item.frame_start = (i == 0 && fs_first) || (noisy && $urandom_range(299) == 0);
      s.item.draw_first  = random_draw();
      s.item.draw_second = random_draw();
      s.pinned_count = NOT_PINNED;
      s.pin_first    = CELL_EMPTY;
      s.pin_second   = CELL_EMPTY;
      cell_queue.push_back(s);
      random_items++;
    end
  endtask

  initial begin : stimulus
    stim_t                 s;
    int                    row_choices [10];
    int                    phase_no, span, frames, rows;
    logic [CFG_DATA_W-1:0] row_data;
    row_choices = '{0, 1, 2, 3, 4, 5, 6, 8, 13, 24};
    cells_ch.valid   = 1'b0;
    cells_ch.payload = '0;
    results_ch.ready = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // hand-worked frame on reset thresholds, three cells per row
    write_reg(REG_ROW_LENGTH, 16'd3);
    cfg_write <= 1'b0;
    foreach (directed_rows[i]) begin
      s.item.cell_state  = directed_rows[i].cell_in;
      s.item.frame_start = directed_rows[i].fs;
      s.item.draw_first  = DRAW_W'(directed_rows[i].draw1);
      s.item.draw_second = DRAW_W'(directed_rows[i].draw2);
      s.pinned_count = directed_rows[i].results;
      s.pin_first    = directed_rows[i].first;
      s.pin_second   = directed_rows[i].second;
      cell_queue.push_back(s);
    end
    settle();

    // row length cut mid-row: the column count runs past the new last column
    set_regs(16'd16384, 16'd2048, 16'd8);
    queue_row(8, 1'b1, 1'b0, 1'b0);
    queue_row(8, 1'b0, 1'b0, 1'b0);
    queue_row(6, 1'b0, 1'b0, 1'b0);
    settle();
    write_reg(REG_ROW_LENGTH, 16'd4);
    cfg_write <= 1'b0;
    queue_row(4, 1'b0, 1'b0, 1'b0);
    queue_row(4, 1'b0, 1'b0, 1'b0);
    queue_row(4, 1'b0, 1'b1, 1'b0);
    settle();

    // full width, then a long result stall once results flow so the input backs up
    set_regs(16'd32768, 16'd0, 16'hFFFF);
    queue_row(MAX_WIDTH, 1'b1, 1'b0, 1'b0);
    queue_row(PRESSURE_CELLS, 1'b0, 1'b0, 1'b0);
    while (expected_cells.size() == 0) @(posedge clk);
    hold_request = 1'b1;
    settle();

    phase_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      span = row_choices[$urandom_range(9)];
      row_data = ($urandom_range(3) == 0) ? {6'($urandom), 10'(span)} : CFG_DATA_W'(span);
      span = clamp_width(span);
      set_regs(pick_threshold(GROW_RESET), pick_threshold(LIGHTNING_RESET), row_data);
      case (phase_no % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 57; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 57; end
        default: begin gap_pct = 22; stall_pct = 22; end
      endcase
      fire_pct = $urandom_range(2, 20);
      tree_pct = $urandom_range(20, 70);
      frames = $urandom_range(2, 4);
      for (int f = 0; f < frames; f++) begin
        rows = $urandom_range(1, 4);
        // now and then a frame follows on without its frame start
        queue_row(span, (f == 0) || ($urandom_range(4) != 0), 1'b0, 1'b1);
        for (int r = 1; r < rows; r++) queue_row(span, 1'b0, 1'b0, 1'b1);
        if ($urandom_range(5) != 0) queue_row(span, 1'b0, 1'b1, 1'b0);
      end
      settle();
      phase_no++;
    end

    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
hw/rtl/ffcu_pkg.sv
hw/rtl/ffcu_if.sv
hw/rtl/ffcu_ram.sv
hw/rtl/ffcu_window.sv
hw/rtl/ffcu_out_queue.sv
hw/rtl/forest_fire_cell_update_core.sv
hw/rtl/ffcu_checker.sv
test/tb_forest_fire_cell_update_core.sv
